>>> hdl/tqla_pkg.sv
package tqla_pkg;

	localparam int STATES_DEF  = 1024;
	localparam int ACTIONS_DEF = 5;

	localparam int OP_W    = 2;
	localparam int IDX_W   = 10;
	localparam int ACT_W   = 3;
	localparam int VAL_W   = 32;
	localparam int RATE_W  = 17;
	localparam int DRAW_W  = 16;
	localparam int DATA_W  = 32;
	localparam int PADDR_W = 5;

	localparam logic [RATE_W-1:0] ONE_Q16     = 17'd65536;
	localparam logic [RATE_W-1:0] LR_RST      = 17'd6554;
	localparam logic [RATE_W-1:0] DISC_RST    = 17'd62259;
	localparam logic [RATE_W-1:0] EPS_RST     = 17'd6554;
	localparam logic [RATE_W-1:0] EPS_MIN_RST = 17'd655;
	localparam logic [RATE_W-1:0] DECAY_RST   = 17'd65208;

	typedef enum logic [OP_W-1:0] {
		OP_CHOOSE = 2'd0,
		OP_LEARN  = 2'd1,
		OP_DECAY  = 2'd2,
		OP_UNUSED = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_LEARNING_RATE   = 3'd0,
		REG_DISCOUNT        = 3'd1,
		REG_INIT_EXPLORE    = 3'd2,
		REG_MIN_EXPLORE     = 3'd3,
		REG_EXPLORE_DECAY   = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		MUL_GAMMA = 2'd0,
		MUL_ALPHA = 2'd1,
		MUL_DECAY = 2'd2
	} mul_sel_t;

	typedef enum logic [2:0] {
		RES_NONE    = 3'd0,
		RES_EXPLORE = 3'd1,
		RES_GREEDY  = 3'd2,
		RES_LEARN   = 3'd3,
		RES_DECAY   = 3'd4,
		RES_ZERO    = 3'd5
	} res_op_t;

	typedef struct packed {
		logic [RATE_W-1:0] learning_rate;
		logic [RATE_W-1:0] discount;
		logic [RATE_W-1:0] initial_explore_rate;
		logic [RATE_W-1:0] min_explore_rate;
		logic [RATE_W-1:0] explore_decay;
		logic              reload;
	} cfg_t;

	typedef struct packed {
		logic     capture;
		logic     clr_en;
		logic     rd_next;
		logic     max_en;
		logic     cur_en;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     diff_en;
		res_op_t  res_op;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic explore;
		logic act_ok;
		logic clr_last;
		logic out_full;
	} sts_t;

	function automatic logic [ACT_W-1:0] act_mod(input logic [ACT_W-1:0] x, input int m);
		logic [ACT_W-1:0] r;
		r = x;
		for (int i = 0; i < 4; i++) begin
			if (32'(r) >= m) begin
				r = r - ACT_W'(m);
			end
		end
		return r;
	endfunction

endpackage

>>> hdl/tabular_q_learning_agent_unit.sv
// Tabular Q-learning agent with epsilon-greedy action choice.
// Requests enter on in_valid/in_stall: operation 0 picks an action for
// state_index, 1 updates Q(state_index, taken_action) from reward and the best
// value of next_state_index, 2 decays epsilon. Each request yields one result on
// out_valid/out_stall with chosen_action, explored, updated_value and the
// epsilon in force afterward.
// After a request is accepted the controller passes through DECODE to DONE
// for an exploring pick, an ignored code or a learn with an out-of-range
// taken_action, through CH_MAX for a greedy pick, DC_UPD for decay, and
// LN_MAX, LN_MUL1, LN_DIFF, LN_MUL2 and LN_WB for a learn update; no new
// request is taken until the last result is loaded. The learn path is set by
// the two dependent multiplies through the single shared multiplier and the
// registered read of the per-action table memories.
// The output register holds a finished result while out_stall is high; a new
// request is still accepted, and its result waits in the block until the
// output register frees.
// After reset the table is cleared one row per cycle with in_stall
// high; configuration writes over the APB port are taken throughout.
module tabular_q_learning_agent_unit #(
	parameter int STATES  = tqla_pkg::STATES_DEF,
	parameter int ACTIONS = tqla_pkg::ACTIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [tqla_pkg::PADDR_W-1:0]       paddr,
	input  logic [tqla_pkg::DATA_W-1:0]        pwdata,
	output logic [tqla_pkg::DATA_W-1:0]        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [tqla_pkg::OP_W-1:0]          operation,
	input  logic [tqla_pkg::IDX_W-1:0]         state_index,
	input  logic [tqla_pkg::IDX_W-1:0]         next_state_index,
	input  logic [tqla_pkg::ACT_W-1:0]         taken_action,
	input  logic signed [tqla_pkg::VAL_W-1:0]  reward,
	input  logic                               greedy_only,
	input  logic [tqla_pkg::DRAW_W-1:0]        random_draw,
	input  logic [tqla_pkg::ACT_W-1:0]         random_action,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tqla_pkg::ACT_W-1:0]         chosen_action,
	output logic                               explored,
	output logic signed [tqla_pkg::VAL_W-1:0]  updated_value,
	output logic [tqla_pkg::RATE_W-1:0]        explore_rate_now
);

	tqla_pkg::cfg_t cfg;
	tqla_pkg::cmd_t cmd;
	tqla_pkg::sts_t sts;

	assign pready = 1'b1;

	tqla_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	tqla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	tqla_dp #(
		.STATES  (STATES),
		.ACTIONS (ACTIONS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg              (cfg),
		.operation        (operation),
		.state_index      (state_index),
		.next_state_index (next_state_index),
		.taken_action     (taken_action),
		.reward           (reward),
		.greedy_only      (greedy_only),
		.random_draw      (random_draw),
		.random_action    (random_action),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.chosen_action    (chosen_action),
		.explored         (explored),
		.updated_value    (updated_value),
		.explore_rate_now (explore_rate_now)
	);

endmodule

>>> hdl/tqla_ram.sv
module tqla_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/tqla_regs.sv
module tqla_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tqla_pkg::PADDR_W-1:0]    paddr,
	input  logic [tqla_pkg::DATA_W-1:0]     pwdata,
	output logic [tqla_pkg::DATA_W-1:0]     prdata,
	output tqla_pkg::cfg_t                  cfg
);

	logic [tqla_pkg::RATE_W-1:0] lr_q, disc_q, init_q, min_q, decay_q;
	logic                        reload_q;
	logic                        wr;
	logic [tqla_pkg::RATE_W-1:0] wval;
	tqla_pkg::reg_idx_t          idx;
	logic [tqla_pkg::RATE_W-1:0] rval;

	assign wr   = psel && penable && pwrite;
	assign idx  = tqla_pkg::reg_idx_t'(paddr[4:2]);
	assign wval = (pwdata > 32'd65536) ? tqla_pkg::ONE_Q16 : pwdata[tqla_pkg::RATE_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q     <= tqla_pkg::LR_RST;
			disc_q   <= tqla_pkg::DISC_RST;
			init_q   <= tqla_pkg::EPS_RST;
			min_q    <= tqla_pkg::EPS_MIN_RST;
			decay_q  <= tqla_pkg::DECAY_RST;
			reload_q <= 1'b0;
		end else begin
			reload_q <= 1'b0;
			if (wr) begin
				unique case (idx)
					tqla_pkg::REG_LEARNING_RATE: lr_q <= wval;
					tqla_pkg::REG_DISCOUNT:      disc_q <= wval;
					tqla_pkg::REG_INIT_EXPLORE: begin
						init_q   <= wval;
						reload_q <= 1'b1;
					end
					tqla_pkg::REG_MIN_EXPLORE:   min_q <= wval;
					tqla_pkg::REG_EXPLORE_DECAY: decay_q <= wval;
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		unique case (idx)
			tqla_pkg::REG_LEARNING_RATE: rval = lr_q;
			tqla_pkg::REG_DISCOUNT:      rval = disc_q;
			tqla_pkg::REG_INIT_EXPLORE:  rval = init_q;
			tqla_pkg::REG_MIN_EXPLORE:   rval = min_q;
			tqla_pkg::REG_EXPLORE_DECAY: rval = decay_q;
			default:                     rval = '0;
		endcase
	end

	assign prdata = tqla_pkg::DATA_W'(rval);

	assign cfg = '{
		learning_rate:        lr_q,
		discount:             disc_q,
		initial_explore_rate: init_q,
		min_explore_rate:     min_q,
		explore_decay:        decay_q,
		reload:               reload_q
	};

endmodule

>>> hdl/tqla_ctrl.sv
module tqla_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  tqla_pkg::sts_t      sts,
	output tqla_pkg::cmd_t      cmd
);

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_CH_MAX,
		ST_LN_MAX,
		ST_LN_MUL1,
		ST_LN_DIFF,
		ST_LN_MUL2,
		ST_LN_WB,
		ST_DC_UPD,
		ST_DONE
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (sts.op)
					tqla_pkg::OP_CHOOSE: begin
						if (sts.explore) begin
							cmd.res_op = tqla_pkg::RES_EXPLORE;
							state_d    = ST_DONE;
						end else begin
							cmd.rd_next = 1'b0;
							state_d     = ST_CH_MAX;
						end
					end
					tqla_pkg::OP_LEARN: begin
						if (sts.act_ok) begin
							cmd.rd_next = 1'b1;
							state_d     = ST_LN_MAX;
						end else begin
							cmd.res_op = tqla_pkg::RES_ZERO;
							state_d    = ST_DONE;
						end
					end
					tqla_pkg::OP_DECAY: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = tqla_pkg::MUL_DECAY;
						state_d     = ST_DC_UPD;
					end
					default: begin
						cmd.res_op = tqla_pkg::RES_ZERO;
						state_d    = ST_DONE;
					end
				endcase
			end
			ST_CH_MAX: begin
				cmd.res_op = tqla_pkg::RES_GREEDY;
				state_d    = ST_DONE;
			end
			ST_LN_MAX: begin
				cmd.max_en  = 1'b1;
				cmd.rd_next = 1'b0;
				state_d     = ST_LN_MUL1;
			end
			ST_LN_MUL1: begin
				cmd.cur_en  = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tqla_pkg::MUL_GAMMA;
				state_d     = ST_LN_DIFF;
			end
			ST_LN_DIFF: begin
				cmd.diff_en = 1'b1;
				state_d     = ST_LN_MUL2;
			end
			ST_LN_MUL2: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tqla_pkg::MUL_ALPHA;
				state_d     = ST_LN_WB;
			end
			ST_LN_WB: begin
				cmd.res_op = tqla_pkg::RES_LEARN;
				state_d    = ST_DONE;
			end
			ST_DC_UPD: begin
				cmd.res_op = tqla_pkg::RES_DECAY;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (!sts.out_full) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

endmodule

>>> hdl/tqla_dp.sv
module tqla_dp #(
	parameter int STATES  = tqla_pkg::STATES_DEF,
	parameter int ACTIONS = tqla_pkg::ACTIONS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tqla_pkg::cmd_t                     cmd,
	output tqla_pkg::sts_t                     sts,
	input  tqla_pkg::cfg_t                     cfg,
	input  logic [tqla_pkg::OP_W-1:0]          operation,
	input  logic [tqla_pkg::IDX_W-1:0]         state_index,
	input  logic [tqla_pkg::IDX_W-1:0]         next_state_index,
	input  logic [tqla_pkg::ACT_W-1:0]         taken_action,
	input  logic signed [tqla_pkg::VAL_W-1:0]  reward,
	input  logic                               greedy_only,
	input  logic [tqla_pkg::DRAW_W-1:0]        random_draw,
	input  logic [tqla_pkg::ACT_W-1:0]         random_action,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [tqla_pkg::ACT_W-1:0]         chosen_action,
	output logic                               explored,
	output logic signed [tqla_pkg::VAL_W-1:0]  updated_value,
	output logic [tqla_pkg::RATE_W-1:0]        explore_rate_now
);

	localparam int IDX_W  = tqla_pkg::IDX_W;
	localparam int ACT_W  = tqla_pkg::ACT_W;
	localparam int VAL_W  = tqla_pkg::VAL_W;
	localparam int RATE_W = tqla_pkg::RATE_W;
	localparam int ROW_W  = $clog2(STATES);
	localparam int AW     = $clog2(ACTIONS);
	localparam int RCP_SH = 20;
	localparam int QP_W   = IDX_W + RCP_SH;
	localparam int unsigned RCP = ((1 << RCP_SH) + STATES - 1) / STATES;
	localparam logic [IDX_W-1:0] ROW_MOD = IDX_W'(STATES);
	localparam int MA_W   = RATE_W + 1;
	localparam int MB_W   = VAL_W + 2;
	localparam int PROD_W = MA_W + MB_W;
	localparam int SC_W   = PROD_W - 16;

	tqla_pkg::op_t               op_q;
	logic [IDX_W-1:0]            sidx_q, nidx_q, sq_q, nq_q;
	logic [ACT_W-1:0]            act_q, ract_q;
	logic signed [VAL_W-1:0]     reward_q;
	logic                        exploit_q;
	logic [tqla_pkg::DRAW_W-1:0] draw_q;

	logic [RATE_W-1:0]           eps_q;
	logic [ROW_W-1:0]            clr_q;
	logic                        out_valid_q;

	logic signed [VAL_W-1:0]     maxval_q, cur_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [MB_W-1:0]      diff_q;

	logic [ACT_W-1:0]            res_act_q;
	logic                        res_expl_q;
	logic signed [VAL_W-1:0]     res_val_q;

	logic [ACT_W-1:0]            out_act_q;
	logic                        out_expl_q;
	logic signed [VAL_W-1:0]     out_val_q;
	logic [RATE_W-1:0]           out_eps_q;

	logic [QP_W-1:0]             sq_prod, nq_prod;
	logic [IDX_W-1:0]            srow10, nrow10;
	logic [ROW_W-1:0]            row_s, row_n, raddr, waddr;
	logic [AW-1:0]               act_idx;
	logic signed [VAL_W-1:0]     rd_row [ACTIONS];
	logic signed [VAL_W-1:0]     best_val;
	logic [AW-1:0]               best_idx;
	logic signed [MA_W-1:0]      mul_a;
	logic signed [MB_W-1:0]      mul_b;
	logic signed [PROD_W-1:0]    mul_p;
	logic signed [SC_W-1:0]      scaled;
	logic signed [SC_W-1:0]      nv;
	logic signed [VAL_W-1:0]     nv_sat;
	logic [RATE_W-1:0]           eps_dec, eps_next;
	logic                        learn_wr;

	assign sq_prod = QP_W'(state_index) * QP_W'(RCP);
	assign nq_prod = QP_W'(next_state_index) * QP_W'(RCP);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= tqla_pkg::op_t'(operation);
			sidx_q    <= state_index;
			nidx_q    <= next_state_index;
			sq_q      <= sq_prod[QP_W-1:RCP_SH];
			nq_q      <= nq_prod[QP_W-1:RCP_SH];
			act_q     <= taken_action;
			reward_q  <= reward;
			exploit_q <= greedy_only;
			draw_q    <= random_draw;
			ract_q    <= random_action;
		end
	end

	assign srow10  = sidx_q - IDX_W'(sq_q * ROW_MOD);
	assign nrow10  = nidx_q - IDX_W'(nq_q * ROW_MOD);
	assign row_s   = ROW_W'(srow10);
	assign row_n   = ROW_W'(nrow10);
	assign raddr   = cmd.rd_next ? row_n : row_s;
	assign waddr   = cmd.clr_en ? clr_q : row_s;
	assign act_idx = AW'(act_q);
	assign learn_wr = (cmd.res_op == tqla_pkg::RES_LEARN);

	for (genvar a = 0; a < ACTIONS; a++) begin : g_lane
		logic lane_we;
		assign lane_we = cmd.clr_en || (learn_wr && (act_idx == AW'(a)));
		tqla_ram #(
			.WIDTH (VAL_W),
			.DEPTH (STATES)
		) u_ram (
			.clk   (clk),
			.we    (lane_we),
			.waddr (waddr),
			.wdata (cmd.clr_en ? '0 : nv_sat),
			.raddr (raddr),
			.rdata (rd_row[a])
		);
	end

	always_comb begin
		best_idx = '0;
		best_val = rd_row[0];
		for (int i = 1; i < ACTIONS; i++) begin
			if (rd_row[i] > best_val) begin
				best_val = rd_row[i];
				best_idx = AW'(i);
			end
		end
	end

	always_comb begin
		unique case (cmd.mul_sel)
			tqla_pkg::MUL_GAMMA: begin
				mul_a = MA_W'({1'b0, cfg.discount});
				mul_b = MB_W'(maxval_q);
			end
			tqla_pkg::MUL_ALPHA: begin
				mul_a = MA_W'({1'b0, cfg.learning_rate});
				mul_b = diff_q;
			end
			tqla_pkg::MUL_DECAY: begin
				mul_a = MA_W'({1'b0, cfg.explore_decay});
				mul_b = MB_W'({1'b0, eps_q});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p  = mul_a * mul_b;
	assign scaled = prod_q[PROD_W-1:16];

	always_ff @(posedge clk) begin
		if (cmd.max_en) begin
			maxval_q <= best_val;
		end
		if (cmd.cur_en) begin
			cur_q <= rd_row[act_idx];
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.diff_en) begin
			diff_q <= MB_W'(reward_q) + MB_W'(scaled) - MB_W'(cur_q);
		end
	end

	assign nv = SC_W'(cur_q) + scaled;

	always_comb begin
		if (nv[SC_W-1:VAL_W-1] == '0 || nv[SC_W-1:VAL_W-1] == '1) begin
			nv_sat = nv[VAL_W-1:0];
		end else if (nv[SC_W-1]) begin
			nv_sat = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			nv_sat = {1'b0, {(VAL_W-1){1'b1}}};
		end
	end

	assign eps_dec  = scaled[RATE_W-1:0];
	assign eps_next = (eps_dec > cfg.min_explore_rate) ? eps_dec : cfg.min_explore_rate;

	always_ff @(posedge clk) begin
		if (cmd.res_op != tqla_pkg::RES_NONE) begin
			res_act_q  <= '0;
			res_expl_q <= 1'b0;
			res_val_q  <= '0;
			unique case (cmd.res_op)
				tqla_pkg::RES_EXPLORE: begin
					res_act_q  <= tqla_pkg::act_mod(ract_q, ACTIONS);
					res_expl_q <= 1'b1;
				end
				tqla_pkg::RES_GREEDY: res_act_q <= ACT_W'(best_idx);
				tqla_pkg::RES_LEARN:  res_val_q <= nv_sat;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q       <= tqla_pkg::EPS_RST;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.reload) begin
				eps_q <= cfg.initial_explore_rate;
			end else if (cmd.res_op == tqla_pkg::RES_DECAY) begin
				eps_q <= eps_next;
			end
			if (cmd.clr_en) begin
				clr_q <= clr_q + ROW_W'(1);
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_act_q  <= res_act_q;
			out_expl_q <= res_expl_q;
			out_val_q  <= res_val_q;
			out_eps_q  <= eps_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign chosen_action    = out_act_q;
	assign explored         = out_expl_q;
	assign updated_value    = out_val_q;
	assign explore_rate_now = out_eps_q;

	assign sts = '{
		op:       op_q,
		explore:  !exploit_q && ({1'b0, draw_q} < eps_q),
		act_ok:   (32'(act_q) < ACTIONS),
		clr_last: (clr_q == ROW_W'(STATES - 1)),
		out_full: out_valid_q && out_stall
	};

endmodule

>>> sim/tb_tabular_q_learning_agent_unit.sv
`timescale 1ns / 100ps

module tb_tabular_q_learning_agent_unit;

	localparam int  OP_W             = tqla_pkg::OP_W;
	localparam int  IDX_W            = tqla_pkg::IDX_W;
	localparam int  ACT_W            = tqla_pkg::ACT_W;
	localparam int  VAL_W            = tqla_pkg::VAL_W;
	localparam int  RATE_W           = tqla_pkg::RATE_W;
	localparam int  DRAW_W           = tqla_pkg::DRAW_W;
	localparam int  DATA_W           = tqla_pkg::DATA_W;
	localparam int  PADDR_W          = tqla_pkg::PADDR_W;
	localparam int  STATES_DEF       = tqla_pkg::STATES_DEF;
	localparam int  ACTIONS_DEF      = tqla_pkg::ACTIONS_DEF;
	localparam int  WATCHDOG_LIMIT   = 6000;
	localparam int  SETTLE_CYCLES    = 12;
	localparam int  MAX_REPORTS      = 10;
	localparam int  UNMAPPED_REG_IDX = 7;
	localparam int  TABLE_DEPTH      = STATES_DEF * ACTIONS_DEF;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;

	typedef struct {
		tqla_pkg::op_t           op;
		logic [IDX_W-1:0]        state_index;
		logic [IDX_W-1:0]        next_state_index;
		logic [ACT_W-1:0]        taken_action;
		logic signed [VAL_W-1:0] reward;
		logic                    greedy_only;
		logic [DRAW_W-1:0]       random_draw;
		logic [ACT_W-1:0]        random_action;
	} agent_req_t;

	typedef struct {
		logic [ACT_W-1:0]        chosen_action;
		logic                    explored;
		logic signed [VAL_W-1:0] updated_value;
		logic [RATE_W-1:0]       explore_rate_now;
	} agent_res_t;

	class q_agent_scoreboard;
		int                q_table [TABLE_DEPTH];
		logic [RATE_W-1:0] alpha;
		logic [RATE_W-1:0] disc;
		logic [RATE_W-1:0] eps_start;
		logic [RATE_W-1:0] eps_floor;
		logic [RATE_W-1:0] eps_mult;
		logic [RATE_W-1:0] eps_live;
		agent_res_t        pending [$];
		int                errors;

		function new();
			foreach (q_table[i]) q_table[i] = 0;
			alpha     = tqla_pkg::LR_RST;
			disc      = tqla_pkg::DISC_RST;
			eps_start = tqla_pkg::EPS_RST;
			eps_floor = tqla_pkg::EPS_MIN_RST;
			eps_mult  = tqla_pkg::DECAY_RST;
			eps_live  = tqla_pkg::EPS_RST;
			errors    = 0;
		endfunction

		function void write_register(int idx, logic [DATA_W-1:0] value);
			logic [RATE_W-1:0] v;
			v = (value > DATA_W'(tqla_pkg::ONE_Q16)) ? tqla_pkg::ONE_Q16 : value[RATE_W-1:0];
			case (idx)
				tqla_pkg::REG_LEARNING_RATE: alpha = v;
				tqla_pkg::REG_DISCOUNT:      disc = v;
				tqla_pkg::REG_INIT_EXPLORE: begin
					eps_start = v;
					eps_live  = v;
				end
				tqla_pkg::REG_MIN_EXPLORE:   eps_floor = v;
				tqla_pkg::REG_EXPLORE_DECAY: eps_mult = v;
				default: ;
			endcase
		endfunction

		function int row_argmax(int row, output int best_val);
			int best;
			best     = 0;
			best_val = q_table[row * ACTIONS_DEF];
			for (int a = 1; a < ACTIONS_DEF; a++) begin
				if (q_table[row * ACTIONS_DEF + a] > best_val) begin
					best_val = q_table[row * ACTIONS_DEF + a];
					best     = a;
				end
			end
			return best;
		endfunction

		// floor(x * f / 2^16)
		function longint q16_scale(longint x, logic [RATE_W-1:0] f);
			longint p;
			p = x * longint'(f);
			return p >>> 16;
		endfunction

		function void note_request(agent_req_t r);
			agent_res_t e;
			int         row;
			int         next_row;
			int         slot;
			int         best_val;
			longint     cur;
			longint     target;
			longint     nv;
			longint     decayed;
			e.chosen_action = '0;
			e.explored      = 1'b0;
			e.updated_value = '0;
			row      = int'(r.state_index) % STATES_DEF;
			next_row = int'(r.next_state_index) % STATES_DEF;
			case (r.op)
				tqla_pkg::OP_CHOOSE: begin
					if (!r.greedy_only && RATE_W'(r.random_draw) < eps_live) begin
						e.chosen_action = ACT_W'(int'(r.random_action) % ACTIONS_DEF);
						e.explored      = 1'b1;
					end else begin
						e.chosen_action = ACT_W'(row_argmax(row, best_val));
					end
				end
				tqla_pkg::OP_LEARN: begin
					if (int'(r.taken_action) < ACTIONS_DEF) begin
						slot = row * ACTIONS_DEF + int'(r.taken_action);
						cur  = longint'(q_table[slot]);
						void'(row_argmax(next_row, best_val));
						target = longint'(r.reward) + q16_scale(longint'(best_val), disc);
						nv     = cur + q16_scale(target - cur, alpha);
						if (nv > Q_MAX) nv = Q_MAX;
						if (nv < Q_MIN) nv = Q_MIN;
						q_table[slot]   = int'(nv);
						e.updated_value = VAL_W'(nv);
					end
				end
				tqla_pkg::OP_DECAY: begin
					decayed  = (longint'(eps_live) * longint'(eps_mult)) >> 16;
					eps_live = (decayed > longint'(eps_floor)) ? RATE_W'(decayed) : eps_floor;
				end
				default: ;
			endcase
			e.explore_rate_now = eps_live;
			pending.push_back(e);
		endfunction

		function void check_result(agent_res_t got);
			agent_res_t want;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result with none outstanding: ",
						"act=%0d expl=%0d val=%0d eps=%0d",
						$time, got.chosen_action, got.explored, got.updated_value,
						got.explore_rate_now);
				return;
			end
			want = pending.pop_front();
			if (got.chosen_action !== want.chosen_action || got.explored !== want.explored ||
			    got.updated_value !== want.updated_value ||
			    got.explore_rate_now !== want.explore_rate_now) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: result differs: exp act=%0d expl=%0d val=%0d eps=%0d, ",
						"got act=%0d expl=%0d val=%0d eps=%0d",
						$time, want.chosen_action, want.explored, want.updated_value,
						want.explore_rate_now, got.chosen_action, got.explored,
						got.updated_value, got.explore_rate_now);
			end
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [PADDR_W-1:0]      paddr = '0;
	logic [DATA_W-1:0]       pwdata = '0;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic [OP_W-1:0]         operation = '0;
	logic [IDX_W-1:0]        state_index = '0;
	logic [IDX_W-1:0]        next_state_index = '0;
	logic [ACT_W-1:0]        taken_action = '0;
	logic signed [VAL_W-1:0] reward = '0;
	logic                    greedy_only = 1'b0;
	logic [DRAW_W-1:0]       random_draw = '0;
	logic [ACT_W-1:0]        random_action = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [ACT_W-1:0]        chosen_action;
	logic                    explored;
	logic signed [VAL_W-1:0] updated_value;
	logic [RATE_W-1:0]       explore_rate_now;

	q_agent_scoreboard q_check = new();
	int send_idle_pct = 37;
	int recv_idle_pct = 37;
	int hold_left = 0;
	int quiet_cycles = 0;

	tabular_q_learning_agent_unit i_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.psel             (psel),
		.penable          (penable),
		.pwrite           (pwrite),
		.paddr            (paddr),
		.pwdata           (pwdata),
		.prdata           (prdata),
		.pready           (pready),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.operation        (operation),
		.state_index      (state_index),
		.next_state_index (next_state_index),
		.taken_action     (taken_action),
		.reward           (reward),
		.greedy_only      (greedy_only),
		.random_draw      (random_draw),
		.random_action    (random_action),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.chosen_action    (chosen_action),
		.explored         (explored),
		.updated_value    (updated_value),
		.explore_rate_now (explore_rate_now)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		agent_res_t got;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			got.chosen_action    = chosen_action;
			got.explored         = explored;
			got.updated_value    = updated_value;
			got.explore_rate_now = explore_rate_now;
			q_check.check_result(got);
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
		    (out_valid === 1'b1 && out_stall === 1'b0))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tabular_q_learning_agent_unit: mismatch");
			$finish;
		end
	end

	task automatic apb_write(input int idx, input logic [DATA_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= PADDR_W'(idx * 4);
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		q_check.write_register(idx, value);
		@(posedge clk);
	endtask

	task automatic send_request(input agent_req_t r);
		in_valid         <= 1'b1;
		operation        <= r.op;
		state_index      <= r.state_index;
		next_state_index <= r.next_state_index;
		taken_action     <= r.taken_action;
		reward           <= r.reward;
		greedy_only      <= r.greedy_only;
		random_draw      <= r.random_draw;
		random_action    <= r.random_action;
		do @(posedge clk); while (in_stall !== 1'b0);
		q_check.note_request(r);
	endtask

	task automatic send_fields(input tqla_pkg::op_t op, input int s, input int ns, input int a,
			input logic [VAL_W-1:0] rw, input logic ex, input int draw, input int ract);
		agent_req_t r;
		r.op               = op;
		r.state_index      = IDX_W'(s);
		r.next_state_index = IDX_W'(ns);
		r.taken_action     = ACT_W'(a);
		r.reward           = rw;
		r.greedy_only      = ex;
		r.random_draw      = DRAW_W'(draw);
		r.random_action    = ACT_W'(ract);
		send_request(r);
	endtask

	function automatic logic [IDX_W-1:0] pick_row();
		if ($urandom_range(3) == 0)
			return IDX_W'($urandom_range(STATES_DEF - 1));
		return IDX_W'($urandom_range(7)) ^ ($urandom_range(1) ? 10'h3F8 : 10'h000);
	endfunction

	function automatic agent_req_t random_request();
		agent_req_t r;
		int         pick;
		pick = $urandom_range(99);
		if (pick < 40)
			r.op = tqla_pkg::OP_CHOOSE;
		else if (pick < 85)
			r.op = tqla_pkg::OP_LEARN;
		else if (pick < 97)
			r.op = tqla_pkg::OP_DECAY;
		else
			r.op = tqla_pkg::OP_UNUSED;
		r.state_index      = pick_row();
		r.next_state_index = pick_row();
		r.taken_action     = ($urandom_range(19) == 0) ? ACT_W'($urandom_range(7, 5))
		                                                : ACT_W'($urandom_range(4));
		case ($urandom_range(3))
			0: r.reward = $signed(32'($urandom_range(2097152))) - 32'sd1048576;
			1: r.reward = $urandom;
			2: r.reward = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			default: r.reward = {16'($urandom), 16'h0000};
		endcase
		r.greedy_only   = 1'($urandom_range(1));
		r.random_draw   = $urandom_range(1) ? DRAW_W'($urandom) : DRAW_W'($urandom_range(8191));
		r.random_action = ACT_W'($urandom_range(7));
		return r;
	endfunction

	task automatic idle_gap();
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic run_random(input int count);
		repeat (count) begin
			idle_gap();
			send_request(random_request());
		end
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (q_check.pending.size() != 0);
	endtask

	task automatic drain();
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic random_config();
		apb_write(tqla_pkg::REG_LEARNING_RATE, $urandom_range(65536));
		apb_write(tqla_pkg::REG_DISCOUNT, $urandom_range(65536));
		apb_write(tqla_pkg::REG_INIT_EXPLORE, $urandom_range(65536));
		apb_write(tqla_pkg::REG_MIN_EXPLORE, $urandom_range(8192));
		apb_write(tqla_pkg::REG_EXPLORE_DECAY, $urandom_range(65536, 49152));
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_fields(tqla_pkg::OP_CHOOSE, 0, 0, 0, 32'h0, 1'b1, 0, 0);
		send_fields(tqla_pkg::OP_CHOOSE, 0, 0, 0, 32'h0, 1'b0, 0, 7);
		send_fields(tqla_pkg::OP_CHOOSE, 1023, 0, 0, 32'h0, 1'b0, 6553, 5);
		send_fields(tqla_pkg::OP_CHOOSE, 5, 0, 0, 32'h0, 1'b0, 6554, 6);
		send_fields(tqla_pkg::OP_CHOOSE, 5, 0, 0, 32'h0, 1'b0, 65535, 3);
		send_fields(tqla_pkg::OP_LEARN, 0, 1023, 3, 32'h7FFF_FFFF, 1'b0, 0, 0);
		send_fields(tqla_pkg::OP_LEARN, 0, 1023, 1, 32'h7FFF_FFFF, 1'b0, 0, 0);
		send_fields(tqla_pkg::OP_CHOOSE, 0, 0, 0, 32'h0, 1'b1, 0, 4);
		send_fields(tqla_pkg::OP_LEARN, 1023, 0, 4, 32'h8000_0000, 1'b1, 65535, 7);
		send_fields(tqla_pkg::OP_LEARN, 2, 0, 5, 32'h0001_0000, 1'b0, 0, 0);
		send_fields(tqla_pkg::OP_LEARN, 2, 0, 6, 32'hFFFF_0000, 1'b0, 0, 0);
		send_fields(tqla_pkg::OP_LEARN, 2, 0, 7, 32'h7FFF_FFFF, 1'b0, 0, 0);
		send_fields(tqla_pkg::OP_UNUSED, 1023, 1023, 7, 32'hFFFF_FFFF, 1'b1, 65535, 7);
		send_fields(tqla_pkg::OP_CHOOSE, 1023, 0, 0, 32'h0, 1'b1, 0, 0);
		send_fields(tqla_pkg::OP_DECAY, 0, 0, 0, 32'h0, 1'b0, 0, 0);
		send_fields(tqla_pkg::OP_DECAY, 1023, 1023, 7, 32'hFFFF_FFFF, 1'b1, 65535, 7);
		send_fields(tqla_pkg::OP_LEARN, 2, 0, 0, 32'h0, 1'b0, 0, 0);
		send_fields(tqla_pkg::OP_LEARN, 3, 1023, 2, 32'hFFFF_FFFF, 1'b0, 0, 0);
		send_fields(tqla_pkg::OP_CHOOSE, 2, 0, 0, 32'h0, 1'b1, 0, 0);
		run_random(200);
		drain();

		apb_write(tqla_pkg::REG_LEARNING_RATE, 32'd65536);
		apb_write(tqla_pkg::REG_DISCOUNT, 32'd65536);
		apb_write(tqla_pkg::REG_INIT_EXPLORE, 32'hFFFF_FFFF);
		apb_write(tqla_pkg::REG_MIN_EXPLORE, 32'd0);
		apb_write(tqla_pkg::REG_EXPLORE_DECAY, 32'd0);
		apb_write(UNMAPPED_REG_IDX, 32'h0000_1234);
		run_random(200);
		drain();

		apb_write(tqla_pkg::REG_LEARNING_RATE, 32'd0);
		apb_write(tqla_pkg::REG_DISCOUNT, 32'd0);
		apb_write(tqla_pkg::REG_INIT_EXPLORE, 32'd0);
		apb_write(tqla_pkg::REG_MIN_EXPLORE, 32'd65537);
		apb_write(tqla_pkg::REG_EXPLORE_DECAY, 32'd65536);
		run_random(130);
		drain();

		random_config();
		run_random(150);
		hold_left = 300;
		run_random(60);
		wait_results();
		run_random(150);
		drain();

		random_config();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_random(200);
		send_idle_pct = 37;
		recv_idle_pct = 37;
		run_random(100);
		drain();

		if (q_check.errors == 0 && q_check.pending.size() == 0)
			$display("tabular_q_learning_agent_unit: match");
		else
			$display("tabular_q_learning_agent_unit: mismatch");
		$finish;
	end

endmodule
